// ----- hw/rtl/rtuv_pkg.sv -----
// Shared types, constants and helper functions for the RA/Dec to unit vector block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package rtuv_pkg;

	// Default build values that the top level takes for its parameters.
	localparam int unsigned CORDIC_STAGES_DEF = 18;
	localparam int unsigned FRAC_BITS_DEF     = 16;

	// Field widths of one item on either side.
	localparam int unsigned RA_W   = 25;
	localparam int unsigned DEC_W  = 24;
	localparam int unsigned OUT_W  = 18;
	localparam int unsigned IN_TDATA_W  = 56;
	localparam int unsigned OUT_TDATA_W = 56;

	// Binary angle (full turn is 2^32) and CORDIC result width (30 fraction bits).
	localparam int unsigned ANGLE_W   = 32;
	localparam int unsigned TRIG_W    = 32;
	localparam int unsigned TRIG_FRAC = 30;
	localparam int unsigned ATAN_COUNT = 24;
	localparam logic [TRIG_W-1:0] CORDIC_GAIN = 32'd652032874;

	// The two angles travel side by side in lanes.
	localparam int unsigned NUM_LANES = 2;
	localparam int unsigned LANE_RA   = 0;
	localparam int unsigned LANE_DEC  = 1;

	typedef logic [ANGLE_W-1:0]        bam_t;
	typedef logic signed [TRIG_W-1:0]  trig_t;
	typedef logic signed [OUT_W-1:0]   comp_t;

	// Arctangent of 2^-idx as a 32-bit binary angle.
	function automatic bam_t atan_entry(input int unsigned idx);
		bam_t a;
		case (idx)
			0:  a = 32'd536870912;
			1:  a = 32'd316933406;
			2:  a = 32'd167458907;
			3:  a = 32'd85004756;
			4:  a = 32'd42667331;
			5:  a = 32'd21354465;
			6:  a = 32'd10679838;
			7:  a = 32'd5340245;
			8:  a = 32'd2670163;
			9:  a = 32'd1335087;
			10: a = 32'd667544;
			11: a = 32'd333772;
			12: a = 32'd166886;
			13: a = 32'd83443;
			14: a = 32'd41722;
			15: a = 32'd20861;
			16: a = 32'd10430;
			17: a = 32'd5215;
			18: a = 32'd2608;
			19: a = 32'd1304;
			20: a = 32'd652;
			21: a = 32'd326;
			22: a = 32'd163;
			23: a = 32'd81;
			default: a = '0;
		endcase
		return a;
	endfunction

	// Drops sh fraction bits with halves rounded up, then clamps to +/-2^fb.
	// The shift amounts are constant at every call site.
	function automatic comp_t round_sat(input logic signed [63:0] v,
			input int unsigned sh, input int unsigned fb);
		logic signed [63:0] r;
		logic signed [63:0] lim;
		r   = (v + (64'sd1 <<< (sh - 1))) >>> sh;
		lim = 64'sd1 <<< fb;
		if (r > lim) begin
			r = lim;
		end else if (r < -lim) begin
			r = -lim;
		end
		return r[OUT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rtuv_deg2bam.sv -----
// Degree to binary angle conversion for both lanes, two pipeline stages.
// Uses rtuv_pkg; the division by 360 * 2^FRAC_BITS is a split reciprocal multiply.
`default_nettype none

module rtuv_deg2bam
	import rtuv_pkg::*;
#(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire logic [RA_W-1:0] mag [NUM_LANES],
	input  wire logic            neg [NUM_LANES],
	output logic                 out_valid,
	output bam_t                 bam [NUM_LANES]
);

	// round(mag * 2^32 / (45 * 2^(FRAC_BITS+3))) = floor((mag * 2^SHL + 22) / 45)
	localparam int unsigned SHL = 29 - FRAC_BITS;
	localparam int unsigned VW  = RA_W + SHL;
	localparam int unsigned K   = VW + 6;
	localparam int unsigned MW  = VW + 1;
	localparam int unsigned H   = (MW + 1) / 2;
	localparam int unsigned PW  = VW + MW;
	localparam logic [63:0] RECIP = ((64'd1 << K) + 64'd44) / 64'd45;
	localparam logic [MW-H-1:0] RECIP_HI = RECIP[MW-1:H];
	localparam logic [H-1:0]    RECIP_LO = RECIP[H-1:0];
	localparam logic [VW-1:0]   HALF_DIV = VW'(22);

	logic                  valid_s1;
	logic                  valid_s2;
	logic [2*H-1:0]        pp_ll_s1 [NUM_LANES];
	logic [MW-1:0]         pp_lh_s1 [NUM_LANES];
	logic [VW-1:0]         pp_hl_s1 [NUM_LANES];
	logic [PW-2*H-1:0]     pp_hh_s1 [NUM_LANES];
	logic                  neg_s1   [NUM_LANES];
	bam_t                  bam_s2   [NUM_LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		logic [VW-1:0]    num;
		logic [VW-H-1:0]  num_hi;
		logic [H-1:0]     num_lo;
		logic [PW-1:0]    prod;
		bam_t             quot;

		assign num    = (VW'(mag[l]) << SHL) + HALF_DIV;
		assign num_hi = num[VW-1:H];
		assign num_lo = num[H-1:0];

		always_ff @(posedge clk) begin
			if (en) begin
				pp_ll_s1[l] <= (2*H)'(num_lo) * (2*H)'(RECIP_LO);
				pp_lh_s1[l] <= MW'(num_lo) * MW'(RECIP_HI);
				pp_hl_s1[l] <= VW'(num_hi) * VW'(RECIP_LO);
				pp_hh_s1[l] <= (PW-2*H)'(num_hi) * (PW-2*H)'(RECIP_HI);
				neg_s1[l]   <= neg[l];
			end
		end

		assign prod = PW'(pp_ll_s1[l]) + (PW'(pp_lh_s1[l]) << H)
			+ (PW'(pp_hl_s1[l]) << H) + (PW'(pp_hh_s1[l]) << (2*H));
		assign quot = ANGLE_W'(prod >> K);

		always_ff @(posedge clk) begin
			if (en) begin
				bam_s2[l] <= neg_s1[l] ? (-quot) : quot;
			end
		end

		assign bam[l] = bam_s2[l];
	end

	assign out_valid = valid_s2;

endmodule

`default_nettype wire

// ----- hw/rtl/rtuv_cordic.sv -----
// Pipelined rotation-mode CORDIC giving cosine and sine of two binary angles.
// Uses rtuv_pkg for the arctangent table, gain and widths.
`default_nettype none

module rtuv_cordic
	import rtuv_pkg::*;
#(
	parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire bam_t angle [NUM_LANES],
	output logic      out_valid,
	output trig_t     cos_out [NUM_LANES],
	output trig_t     sin_out [NUM_LANES]
);

	localparam int unsigned N  = (CORDIC_STAGES > ATAN_COUNT) ? ATAN_COUNT : CORDIC_STAGES;
	localparam int unsigned CW = TRIG_W + 1;
	localparam logic signed [CW-1:0] QUARTER = CW'(64'sd1 <<< 30);
	localparam logic signed [CW-1:0] HALF    = CW'(64'sd1 <<< 31);
	localparam logic signed [CW-1:0] X_INIT  = signed'(CW'(CORDIC_GAIN));

	// Stage 0 is the quadrant fold, stages 1..N the rotations, N+1 the sign fix.
	logic [N+1:0]           valid_s;
	logic signed [CW-1:0]   x_s    [NUM_LANES][N+1];
	logic signed [CW-1:0]   y_s    [NUM_LANES][N+1];
	logic signed [CW-1:0]   z_s    [NUM_LANES][N+1];
	logic                   flip_s [NUM_LANES][N+1];
	trig_t                  cos_sn [NUM_LANES];
	trig_t                  sin_sn [NUM_LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[N:0], in_valid};
		end
	end

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		logic signed [CW-1:0] z_in;

		assign z_in = CW'(signed'(angle[l]));

		// Angles past a quarter turn are turned by a half turn and the result negated.
		always_ff @(posedge clk) begin
			if (en) begin
				x_s[l][0] <= X_INIT;
				y_s[l][0] <= '0;
				if (z_in > QUARTER) begin
					z_s[l][0]    <= z_in - HALF;
					flip_s[l][0] <= 1'b1;
				end else if (z_in < -QUARTER) begin
					z_s[l][0]    <= z_in + HALF;
					flip_s[l][0] <= 1'b1;
				end else begin
					z_s[l][0]    <= z_in;
					flip_s[l][0] <= 1'b0;
				end
			end
		end

		for (genvar i = 0; i < N; i++) begin : g_iter
			localparam logic signed [CW-1:0] ATAN = signed'(CW'(atan_entry(i)));
			logic signed [CW-1:0] dx;
			logic signed [CW-1:0] dy;

			assign dx = y_s[l][i] >>> i;
			assign dy = x_s[l][i] >>> i;

			always_ff @(posedge clk) begin
				if (en) begin
					flip_s[l][i+1] <= flip_s[l][i];
					if (z_s[l][i] >= 0) begin
						x_s[l][i+1] <= x_s[l][i] - dx;
						y_s[l][i+1] <= y_s[l][i] + dy;
						z_s[l][i+1] <= z_s[l][i] - ATAN;
					end else begin
						x_s[l][i+1] <= x_s[l][i] + dx;
						y_s[l][i+1] <= y_s[l][i] - dy;
						z_s[l][i+1] <= z_s[l][i] + ATAN;
					end
				end
			end
		end

		// Results stay near 2^30 in magnitude, so 32 bits hold them.
		always_ff @(posedge clk) begin
			if (en) begin
				if (flip_s[l][N]) begin
					cos_sn[l] <= TRIG_W'(-x_s[l][N]);
					sin_sn[l] <= TRIG_W'(-y_s[l][N]);
				end else begin
					cos_sn[l] <= TRIG_W'(x_s[l][N]);
					sin_sn[l] <= TRIG_W'(y_s[l][N]);
				end
			end
		end

		assign cos_out[l] = cos_sn[l];
		assign sin_out[l] = sin_sn[l];
	end

	assign out_valid = valid_s[N+1];

endmodule

`default_nettype wire

// ----- hw/rtl/rtuv_scale.sv -----
// Forms cos(dec)cos(ra), cos(dec)sin(ra) and sin(dec) and rounds them to the output format.
// Uses rtuv_pkg for widths and the round-and-clamp function; two pipeline stages.
`default_nettype none

module rtuv_scale
	import rtuv_pkg::*;
#(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire logic  in_valid,
	input  wire trig_t cos_dec,
	input  wire trig_t sin_dec,
	input  wire trig_t cos_ra,
	input  wire trig_t sin_ra,
	output logic       out_valid,
	output comp_t      x_component,
	output comp_t      y_component,
	output comp_t      z_component
);

	localparam int unsigned PROD_SH = 2 * TRIG_FRAC - FRAC_BITS;
	localparam int unsigned TRIG_SH = TRIG_FRAC - FRAC_BITS;

	logic               valid_s1;
	logic               valid_s2;
	logic signed [63:0] px_s1;
	logic signed [63:0] py_s1;
	trig_t              pz_s1;
	comp_t              x_s2;
	comp_t              y_s2;
	comp_t              z_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= 64'(cos_dec) * 64'(cos_ra);
			py_s1 <= 64'(cos_dec) * 64'(sin_ra);
			pz_s1 <= sin_dec;
			x_s2  <= round_sat(px_s1, PROD_SH, FRAC_BITS);
			y_s2  <= round_sat(py_s1, PROD_SH, FRAC_BITS);
			z_s2  <= round_sat(64'(pz_s1), TRIG_SH, FRAC_BITS);
		end
	end

	assign out_valid   = valid_s2;
	assign x_component = x_s2;
	assign y_component = y_s2;
	assign z_component = z_s2;

endmodule

`default_nettype wire

// ----- hw/rtl/radec_to_unit_vector.sv -----
// Top level of the RA/Dec to equatorial unit vector converter.
// Instantiates rtuv_deg2bam, rtuv_cordic and rtuv_scale; uses rtuv_pkg.
//
// Usage:
// One item on the s_axis channel is a star position: right ascension (unsigned degrees)
// and declination (signed degrees), both with FRAC_BITS fraction bits. For every
// accepted item exactly one item leaves on the m_axis channel: the unit vector
// x = cos(dec)cos(ra), y = cos(dec)sin(ra), z = sin(dec), signed with FRAC_BITS
// fraction bits, clamped to +/-1.0. Items leave in the order they came in.
// The pipeline length is set by the CORDIC (its stage count is capped at 24): a
// quadrant fold stage, one rotation per stage and a sign fix stage, plus two
// stages for the degree to binary angle conversion, two for the products and
// rounding, and the output register.
// Throughput is one item per cycle while the receiver takes items.
// Reset clears every valid bit, so the pipeline comes up empty and ready.
// When the receiver stalls, the output register holds its item and one more item
// that was already in flight lands in a skid register; from then on s_axis_tready
// is low and the whole pipeline freezes in place until the skid register drains.
`default_nettype none

module radec_to_unit_vector
	import rtuv_pkg::*;
#(
	parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF,
	parameter int unsigned FRAC_BITS     = FRAC_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// ra_angle [24:0], dec_angle [48:25], zero padding [55:49]
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// x_component [17:0], y_component [35:18], z_component [53:36], zero padding [55:54]
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

	localparam int unsigned PAD_W = OUT_TDATA_W - 3 * OUT_W;

	// Input fields.
	logic [RA_W-1:0]          ra_angle;
	logic signed [DEC_W-1:0]  dec_angle;
	logic [DEC_W-1:0]         dec_mag;

	// Lanes into the angle conversion.
	logic [RA_W-1:0] lane_mag [NUM_LANES];
	logic            lane_neg [NUM_LANES];

	// The whole pipeline advances together; it stops only while the skid register is full.
	logic run;

	logic  bam_valid;
	bam_t  bam [NUM_LANES];
	logic  trig_valid;
	trig_t cos_v [NUM_LANES];
	trig_t sin_v [NUM_LANES];
	logic  res_valid;
	comp_t res_x;
	comp_t res_y;
	comp_t res_z;

	// Output register and skid register.
	logic  out_valid_q;
	comp_t out_x_q;
	comp_t out_y_q;
	comp_t out_z_q;
	logic  skid_valid_q;
	comp_t skid_x_q;
	comp_t skid_y_q;
	comp_t skid_z_q;
	logic  out_free;
	logic  incoming;

	assign ra_angle  = s_axis_tdata[RA_W-1:0];
	assign dec_angle = signed'(s_axis_tdata[RA_W +: DEC_W]);

	// Magnitude of the declination; the most negative code maps to 2^23 as unsigned.
	assign dec_mag = dec_angle[DEC_W-1] ? DEC_W'(-dec_angle) : DEC_W'(dec_angle);

	assign lane_mag[LANE_RA]  = ra_angle;
	assign lane_neg[LANE_RA]  = 1'b0;
	assign lane_mag[LANE_DEC] = RA_W'(dec_mag);
	assign lane_neg[LANE_DEC] = dec_angle[DEC_W-1];

	assign run           = !skid_valid_q;
	assign s_axis_tready = run;

	rtuv_deg2bam #(
		.FRAC_BITS (FRAC_BITS)
	) u_deg2bam (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (run),
		.in_valid  (s_axis_tvalid),
		.mag       (lane_mag),
		.neg       (lane_neg),
		.out_valid (bam_valid),
		.bam       (bam)
	);

	rtuv_cordic #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (run),
		.in_valid  (bam_valid),
		.angle     (bam),
		.out_valid (trig_valid),
		.cos_out   (cos_v),
		.sin_out   (sin_v)
	);

	rtuv_scale #(
		.FRAC_BITS (FRAC_BITS)
	) u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (run),
		.in_valid    (trig_valid),
		.cos_dec     (cos_v[LANE_DEC]),
		.sin_dec     (sin_v[LANE_DEC]),
		.cos_ra      (cos_v[LANE_RA]),
		.sin_ra      (sin_v[LANE_RA]),
		.out_valid   (res_valid),
		.x_component (res_x),
		.y_component (res_y),
		.z_component (res_z)
	);

	// The output register can take an item when it is empty or its item leaves now.
	assign out_free = !out_valid_q || m_axis_tready;
	// An item leaves the pipeline at every edge where it advances with a valid last stage.
	assign incoming = run && res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_free) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (incoming) begin
			if (out_free) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_free) begin
				out_x_q <= skid_x_q;
				out_y_q <= skid_y_q;
				out_z_q <= skid_z_q;
			end
		end else if (incoming) begin
			if (out_free) begin
				out_x_q <= res_x;
				out_y_q <= res_y;
				out_z_q <= res_z;
			end else begin
				skid_x_q <= res_x;
				skid_y_q <= res_y;
				skid_z_q <= res_z;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {PAD_W'(0), out_z_q, out_y_q, out_x_q};

	// The skid register only ever holds the item behind the one waiting at the output.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds an item while the output register is empty");

	// The skid register fills only when the output was held by the receiver.
	a_skid_fill_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
		else $error("skid register filled without a stalled output");

	// A taken output always drains the skid register in the next cycle.
	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && m_axis_tready |=> !skid_valid_q)
		else $error("skid register did not drain after the output was taken");

endmodule

`default_nettype wire

// ----- dv/radec_to_unit_vector_tb.sv -----
// Self-checking testbench for radec_to_unit_vector: star positions in, unit vectors out.
// Predicts every result with its own bit-exact CORDIC model and checks the output stream.
// Depends on rtuv_pkg and the radec_to_unit_vector RTL only.
`timescale 1ns / 100ps

module radec_to_unit_vector_tb;
	import rtuv_pkg::*;

	localparam int unsigned STAGES = CORDIC_STAGES_DEF;
	localparam int unsigned FRAC   = FRAC_BITS_DEF;
	// Acceptance to output valid, from the pipeline stages that the top level lists.
	localparam int unsigned LATENCY = ((STAGES > ATAN_COUNT) ? ATAN_COUNT : STAGES) + 7;
	localparam int DEG = 1 << FRAC;
	localparam int RA_TOP  = 360 * DEG - 1;
	localparam int DEC_TOP = 90 * DEG;
	localparam int RANDOM_PER_PHASE = 200;

	// Which result fields of a directed row carry a hand-typed value.
	localparam logic [2:0] PIN_NONE = 3'b000;
	localparam logic [2:0] PIN_X    = 3'b001;
	localparam logic [2:0] PIN_Y    = 3'b010;
	localparam logic [2:0] PIN_Z    = 3'b100;
	localparam comp_t UNIT = 18'sd65536;

	typedef struct packed {
		comp_t z;
		comp_t y;
		comp_t x;
	} unit_vec_t;

	typedef struct {
		logic [RA_W-1:0]  ra;
		logic [DEC_W-1:0] dec;
		logic [2:0]       pins;
		unit_vec_t        fixed;
	} stim_row_t;

	// Arctangent of 2^-i in binary angle units, a full turn being 2^32.
	localparam longint ATAN_TURNS [0:23] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// Hand-typed fields travel next to the item that is on offer.
	logic [2:0] offer_pins = PIN_NONE;
	unit_vec_t  offer_fixed = '0;

	unit_vec_t pending_vectors[$];
	stim_row_t directed_rows[$];
	int fault_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;

	radec_to_unit_vector #(
		.CORDIC_STAGES(STAGES),
		.FRAC_BITS(FRAC)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	// Degrees with FRAC fraction bits to a binary angle, rounded half up and
	// negated afterwards for a negative declination, kept modulo a full turn.
	function automatic bam_t degrees_to_turns(input logic [63:0] mag, input bit neg);
		logic [63:0] den;
		logic [63:0] turns;
		den = 64'd360 << FRAC;
		turns = ((mag << 32) + (den >> 1)) / den;
		if (neg) begin
			turns = -turns;
		end
		return turns[ANGLE_W-1:0];
	endfunction

	// Rotation-mode CORDIC with 30 fraction bits. Angles past a quarter turn
	// are folded by half a turn and both results negated afterwards.
	function automatic void cordic_cos_sin(input bam_t angle, output longint cos_v,
			output longint sin_v);
		longint resid;
		longint xv;
		longint yv;
		longint dx;
		longint dy;
		bit folded;
		int n;
		resid = longint'($signed(angle));
		folded = 1'b0;
		xv = longint'(CORDIC_GAIN);
		yv = 0;
		n = (STAGES > ATAN_COUNT) ? ATAN_COUNT : STAGES;
		if (resid > (64'sd1 <<< 30)) begin
			resid = resid - (64'sd1 <<< 31);
			folded = 1'b1;
		end else if (resid < -(64'sd1 <<< 30)) begin
			resid = resid + (64'sd1 <<< 31);
			folded = 1'b1;
		end
		for (int i = 0; i < n; i++) begin
			dx = yv >>> i;
			dy = xv >>> i;
			if (resid >= 0) begin
				xv = xv - dx;
				yv = yv + dy;
				resid = resid - ATAN_TURNS[i];
			end else begin
				xv = xv + dx;
				yv = yv - dy;
				resid = resid + ATAN_TURNS[i];
			end
		end
		cos_v = folded ? -xv : xv;
		sin_v = folded ? -yv : yv;
	endfunction

	// Drop fraction bits with halves toward plus infinity, then clamp to +/-1.0.
	function automatic comp_t to_output_format(input longint v, input int drop);
		longint r;
		longint lim;
		r = (v + (64'sd1 <<< (drop - 1))) >>> drop;
		lim = 64'sd1 <<< FRAC;
		if (r > lim) begin
			r = lim;
		end else if (r < -lim) begin
			r = -lim;
		end
		return r[OUT_W-1:0];
	endfunction

	function automatic unit_vec_t predict_unit_vector(input logic [RA_W-1:0] ra,
			input logic [DEC_W-1:0] dec);
		logic [63:0] dec_mag;
		longint cos_ra;
		longint sin_ra;
		longint cos_dec;
		longint sin_dec;
		unit_vec_t vec;
		dec_mag = dec[DEC_W-1] ? ((64'd1 << DEC_W) - 64'(dec)) : 64'(dec);
		cordic_cos_sin(degrees_to_turns(64'(ra), 1'b0), cos_ra, sin_ra);
		cordic_cos_sin(degrees_to_turns(dec_mag, dec[DEC_W-1]), cos_dec, sin_dec);
		vec.x = to_output_format(cos_dec * cos_ra, 2 * TRIG_FRAC - FRAC);
		vec.y = to_output_format(cos_dec * sin_ra, 2 * TRIG_FRAC - FRAC);
		vec.z = to_output_format(sin_dec, TRIG_FRAC - FRAC);
		return vec;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic check_field(input string name, input comp_t want, input comp_t got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fault_count++;
		end
	endtask

	// Both channels are watched from one process, so an item taken in and a
	// result leaving on the same edge are handled in a fixed order.
	always @(posedge clk) begin
		unit_vec_t want;
		unit_vec_t got;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				want = predict_unit_vector(s_axis_tdata[RA_W-1:0],
					s_axis_tdata[RA_W+DEC_W-1:RA_W]);
				// Hand-typed values take the place of predicted ones.
				if (offer_pins & PIN_X) want.x = offer_fixed.x;
				if (offer_pins & PIN_Y) want.y = offer_fixed.y;
				if (offer_pins & PIN_Z) want.z = offer_fixed.z;
				pending_vectors.push_back(want);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.x = m_axis_tdata[OUT_W-1:0];
				got.y = m_axis_tdata[2*OUT_W-1:OUT_W];
				got.z = m_axis_tdata[3*OUT_W-1:2*OUT_W];
				if (pending_vectors.size() == 0) begin
					$error("result item with no input pending: x %0d y %0d z %0d",
						got.x, got.y, got.z);
					fault_count++;
				end else begin
					want = pending_vectors.pop_front();
					check_field("x_component", want.x, got.x);
					check_field("y_component", want.y, got.y);
					check_field("z_component", want.z, got.z);
				end
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	// The receiver either holds off for a counted stretch or stalls at random.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ---------------------------------------------------------------- sender

	// Offers one item and returns on the edge where it is taken. Idle cycles
	// come first, so a valid that stays high is never dropped and raised
	// within the same step.
	task automatic offer(input logic [RA_W-1:0] ra, input logic [DEC_W-1:0] dec,
			input logic [2:0] pins, input unit_vec_t fixed);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_TDATA_W - RA_W - DEC_W){1'b0}}, dec, ra};
		offer_pins <= pins;
		offer_fixed <= fixed;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
	endtask

	// Sender goes quiet until every result in flight has come back.
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_vectors.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic add_row(input int ra, input int dec, input logic [2:0] pins,
			input unit_vec_t fixed);
		stim_row_t row;
		row.ra = ra[RA_W-1:0];
		row.dec = dec[DEC_W-1:0];
		row.pins = pins;
		row.fixed = fixed;
		directed_rows.push_back(row);
	endtask

	// Random star positions: mostly anywhere in range, a share close to the
	// quadrant edges where the CORDIC folds its angle, and a share over the
	// whole raw width of both fields, where angles wrap.
	task automatic random_position(output logic [RA_W-1:0] ra, output logic [DEC_W-1:0] dec);
		int pick;
		int ra_v;
		int dec_v;
		pick = $urandom_range(99);
		if (pick < 70) begin
			ra_v = $urandom_range(RA_TOP);
			dec_v = int'($urandom_range(2 * DEC_TOP)) - DEC_TOP;
		end else if (pick < 85) begin
			ra_v = int'($urandom_range(7)) * 45 * DEG + int'($urandom_range(128)) - 64;
			dec_v = int'($urandom_range(4)) * 45 * DEG - DEC_TOP
				+ int'($urandom_range(128)) - 64;
			if (ra_v < 0) ra_v = 0;
			if (dec_v > DEC_TOP) dec_v = DEC_TOP;
			if (dec_v < -DEC_TOP) dec_v = -DEC_TOP;
		end else begin
			ra_v = $urandom;
			dec_v = $urandom;
		end
		ra = ra_v[RA_W-1:0];
		dec = dec_v[DEC_W-1:0];
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		logic [RA_W-1:0] ra;
		logic [DEC_W-1:0] dec;

		// Directed rows. A value is typed in only where it is plain: straight
		// ahead along the vernal equinox gives x of one, and the poles give z
		// of plus or minus one. Everything else goes to the predictor.
		add_row(0, 0, PIN_X, '{z: 0, y: 0, x: UNIT});
		add_row(0, DEC_TOP, PIN_Z, '{z: UNIT, y: 0, x: 0});
		add_row(0, -DEC_TOP, PIN_Z, '{z: -UNIT, y: 0, x: 0});
		add_row(RA_TOP, -DEC_TOP, PIN_Z, '{z: -UNIT, y: 0, x: 0});
		add_row(RA_TOP, 0, PIN_NONE, '0);
		add_row(90 * DEG, 0, PIN_NONE, '0);
		add_row(180 * DEG, 45 * DEG, PIN_NONE, '0);
		add_row(270 * DEG, -45 * DEG, PIN_NONE, '0);
		add_row(45 * DEG, 30 * DEG, PIN_NONE, '0);
		add_row(135 * DEG, -60 * DEG, PIN_NONE, '0);
		add_row(1, 1, PIN_NONE, '0);
		add_row(1, -1, PIN_NONE, '0);
		add_row(25'h0AAAAAA, 24'h2AAAAA, PIN_NONE, '0);
		add_row(25'h1555555, 24'hD55555, PIN_NONE, '0);
		// Right ascension at and past a full turn wraps around.
		add_row(360 * DEG, 0, PIN_NONE, '0);
		add_row(25'h1FFFFFF, DEC_TOP + 1, PIN_NONE, '0);
		// Declination past the poles is taken as the geometric angle.
		add_row(30 * DEG, 120 * DEG, PIN_NONE, '0);
		add_row(210 * DEG, -120 * DEG, PIN_NONE, '0);
		add_row(0, 24'h7FFFFF, PIN_NONE, '0);
		add_row(RA_TOP, 24'h800000, PIN_NONE, '0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			offer(directed_rows[i].ra, directed_rows[i].dec, directed_rows[i].pins,
				directed_rows[i].fixed);
		end
		drain();

		// Four phases of random items with different idle patterns.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					// Long hold-off while the sender keeps pushing: the pipeline
					// and the skid register fill and the input stalls.
					hold_left = 4 * LATENCY;
				end
				1: begin
					send_idle_pct = 49;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 49;
				end
				default: begin
					send_idle_pct = 20;
					recv_stall_pct = 20;
				end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				random_position(ra, dec);
				offer(ra, dec, PIN_NONE, '0);
			end
			drain();
		end

		// Let any stray result show up before closing.
		repeat (2 * LATENCY) @(posedge clk);
		if (pending_vectors.size() != 0) begin
			$error("%0d results never arrived", pending_vectors.size());
			fault_count++;
		end
		if (fault_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
